@@ sv/terminal_line_editor_assert.svh @@
// Assertion macros shared by the terminal line editor.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// Condition in the same cycle implies a consequence in the same cycle.
`define TLE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("terminal_line_editor: assertion failed");

// Condition implies a consequence in the following cycle.
`define TLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("terminal_line_editor: assertion failed");

`endif

@@ sv/tle_pkg.sv @@
// Shared types and constants of the terminal line editor.
`timescale 1ns / 1ps

package tle_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int LIMIT_W    = 6;
    localparam int LEN_W      = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 6'd2;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ECHO_NONE = 2'd0,
        ECHO_CHR  = 2'd1,
        ECHO_BS   = 2'd2,
        ECHO_NL   = 2'd3
    } t_echo;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_ECHO = 3'd1,
        S_PREP = 3'd2,
        S_CHAR = 3'd3,
        S_END  = 3'd4
    } t_bstate;

    // One classified request handed from the front to the back.
    typedef struct packed {
        t_echo            echo;
        logic [7:0]       ch;
        logic             complete;
        logic [LEN_W-1:0] length;
    } t_cmd;

    // Line buffer write from the front.
    typedef struct packed {
        logic               en;
        logic [LINE_AW-1:0] addr;
        logic [7:0]         data;
    } t_wr;

endpackage

@@ sv/tle_front.sv @@
// Front end: accepts received bytes, edits the fill count and classifies each request.
`timescale 1ns / 1ps

module tle_front import tle_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_char,
    input  logic               i_full,
    output logic               o_push,
    output t_cmd               o_cmd,
    output t_wr                o_wr,
    input  logic               i_line_done,
    output logic               o_busy
);

    logic [LIMIT_W-1:0] r_limit;
    logic [LEN_W-1:0]   r_count;
    logic [LEN_W-1:0]   n_count;
    logic               r_busy;
    logic               n_busy;

    logic [LIMIT_W-1:0] w_lim;
    logic [LEN_W-1:0]   w_thr;
    logic               w_bs;
    logic               w_nl;
    logic               w_pr;
    logic               w_accept;
    logic [LEN_W-1:0]   w_cnt;
    logic               w_complete;
    t_echo              w_echo;

    always_comb begin
        if (r_limit < LIMIT_MIN) begin
            w_lim = LIMIT_MIN;
        end else if (r_limit > LIMIT_W'(LINE_DEPTH)) begin
            w_lim = LIMIT_W'(LINE_DEPTH);
        end else begin
            w_lim = r_limit;
        end
    end

    assign w_thr = LEN_W'(w_lim - 1'b1);

    assign w_bs = (i_rx_char == CH_BS) || (i_rx_char == CH_DEL);
    assign w_nl = (i_rx_char == CH_CR) || (i_rx_char == CH_LF);
    assign w_pr = (i_rx_char >= CH_SPACE) && (i_rx_char < CH_DEL);

    always_comb begin
        w_cnt  = r_count;
        w_echo = ECHO_NONE;
        if (w_bs) begin
            if (r_count != '0) begin
                w_cnt  = r_count - 1'b1;
                w_echo = ECHO_BS;
            end
        end else if (w_nl) begin
            w_echo = ECHO_NL;
        end else if (w_pr) begin
            w_cnt  = r_count + 1'b1;
            w_echo = ECHO_CHR;
        end
    end

    assign w_complete = w_nl || (w_cnt >= w_thr);

    assign o_in_ready = !r_busy && !i_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept && ((w_echo != ECHO_NONE) || w_complete);

    assign o_cmd.echo     = w_echo;
    assign o_cmd.ch       = i_rx_char;
    assign o_cmd.complete = w_complete;
    assign o_cmd.length   = w_cnt;

    assign o_wr.en   = w_accept && w_pr;
    assign o_wr.addr = LINE_AW'(r_count);
    assign o_wr.data = i_rx_char;

    assign o_busy = r_busy;

    always_comb begin
        n_count = r_count;
        n_busy  = r_busy;
        if (w_accept) begin
            n_count = w_complete ? '0 : w_cnt;
        end
        if (o_push && w_complete) begin
            n_busy = 1'b1;
        end else if (i_line_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_count <= n_count;
            r_busy  <= n_busy;
        end
    end

endmodule

@@ sv/tle_cmd_fifo.sv @@
// Two-entry request queue between the front and the back.
`timescale 1ns / 1ps

module tle_cmd_fifo import tle_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ sv/tle_back.sv @@
// Back end: line buffer and the sequencer that emits echo, line and line-end results.
`timescale 1ns / 1ps

module tle_back import tle_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_wr              i_wr,
    input  logic             i_empty,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_line_done,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_out_char,
    output logic [LEN_W-1:0] o_line_length,
    output logic             o_last
);

    logic [7:0]         r_line [LINE_DEPTH];
    logic [7:0]         r_rd_data;

    t_bstate            r_state;
    t_bstate            n_state;
    t_cmd               r_cmd;
    logic [1:0]         r_step;
    logic [LINE_AW-1:0] r_idx;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [7:0]         r_out_char;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_last;

    logic               w_load;
    logic               w_echo_final;
    logic               w_line_final;
    logic               w_emit;
    t_kind              w_kind;
    logic [7:0]         w_char;
    logic [LEN_W-1:0]   w_len;
    logic               w_last;

    assign w_load       = !r_out_valid || i_out_ready;
    assign w_echo_final = (r_cmd.echo != ECHO_BS) || (r_step == 2'd2);
    assign w_line_final = (LEN_W'(r_idx) == r_cmd.length - 1'b1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.echo != ECHO_NONE) begin
                        n_state = S_ECHO;
                    end else if (i_cmd.length != '0) begin
                        n_state = S_PREP;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_ECHO: begin
                if (w_load && w_echo_final) begin
                    if (!r_cmd.complete) begin
                        n_state = S_IDLE;
                    end else if (r_cmd.length != '0) begin
                        n_state = S_PREP;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_PREP: begin
                n_state = S_CHAR;
            end
            S_CHAR: begin
                if (w_load) begin
                    n_state = w_line_final ? S_END : S_PREP;
                end
            end
            S_END: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_pop       = 1'b0;
        o_line_done = 1'b0;
        w_emit      = 1'b0;
        w_kind      = KIND_ECHO;
        w_char      = '0;
        w_len       = '0;
        w_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop = !i_empty;
            end
            S_ECHO: begin
                w_emit = w_load;
                w_last = w_echo_final && !r_cmd.complete;
                case (r_cmd.echo)
                    ECHO_BS:  w_char = (r_step == 2'd1) ? CH_SPACE : CH_BS;
                    ECHO_NL:  w_char = CH_LF;
                    default:  w_char = r_cmd.ch;
                endcase
            end
            S_CHAR: begin
                w_emit = w_load;
                w_kind = KIND_CHAR;
                w_char = r_rd_data;
            end
            S_END: begin
                w_emit      = w_load;
                w_kind      = KIND_END;
                w_len       = r_cmd.length;
                w_last      = 1'b1;
                o_line_done = w_load;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // The front never writes while a line is being read out.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_line[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_line[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_emit) begin
            r_out_kind <= w_kind;
            r_out_char <= w_char;
            r_out_len  <= w_len;
            r_out_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_step <= '0;
                r_idx  <= '0;
            end else begin
                if (r_state == S_ECHO && w_load) begin
                    r_step <= r_step + 2'd1;
                end
                if (r_state == S_CHAR && w_load) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_char    = r_out_char;
    assign o_line_length = r_out_len;
    assign o_last        = r_out_last;

endmodule

@@ sv/terminal_line_editor.sv @@
// Top level of the terminal line editor: front end, request queue and back end.
// Path: a byte's request is written into the queue and popped into the sequencer, which
// loads its results into the output register; each line character takes a buffer read in
// S_PREP and a hand-off in S_CHAR, and a backspace echoes BS, space, BS. The queue takes
// bytes one per cycle until full, and input waits from a completion until its line end loads.
// Reset (synchronous, active low) clears count, queue, sequencer; line_limit becomes 32.
`timescale 1ns / 1ps
`include "terminal_line_editor_assert.svh"

module terminal_line_editor import tle_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration: line_limit.
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    // Received byte requests.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_char,
    // Result requests.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_out_kind,
    output logic [7:0]         o_out_char,
    output logic [LEN_W-1:0]   o_line_length,
    output logic               o_last
);

    // Classified requests travel from the front to the back through a short queue, so the
    // front keeps taking keystrokes while the back waits on a stalled output.
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;
    t_wr  w_wr;
    logic w_line_done;
    logic w_busy;

    tle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_char   (i_rx_char),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in),
        .o_wr        (w_wr),
        .i_line_done (w_line_done),
        .o_busy      (w_busy)
    );

    tle_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_empty)
    );

    // The back end owns the line buffer; the front writes it as printable bytes arrive.
    tle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_wr),
        .i_empty       (w_empty),
        .i_cmd         (w_cmd_out),
        .o_pop         (w_pop),
        .o_line_done   (w_line_done),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_kind    (o_out_kind),
        .o_out_char    (o_out_char),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

    // A line-end result always closes the results of its request.
    `TLE_ASSERT_SAME(a_end_is_last, o_out_valid && (o_out_kind == KIND_END), o_last)
    // A delivered character is never the final result of a request.
    `TLE_ASSERT_SAME(a_char_not_last, o_out_valid && (o_out_kind == KIND_CHAR), !o_last)
    // The line buffer is never written while a completed line waits to be read out.
    `TLE_ASSERT_SAME(a_no_write_busy, w_wr.en, !w_busy)
    // After a completion is queued the front holds off further input.
    `TLE_ASSERT_NEXT(a_hold_after_done, w_push && w_cmd_in.complete, !o_in_ready)

endmodule

@@ tb/terminal_line_editor_checker.sv @@
// Checker for the terminal line editor: watches both channels, predicts echo and line output, compares.
`timescale 1ns / 1ps

module terminal_line_editor_checker import tle_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_rx_char,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_out_kind,
    input  logic [7:0]         i_out_char,
    input  logic [LEN_W-1:0]   i_line_length,
    input  logic               i_last,
    output int                 o_pending,
    output int                 o_fail_count
);

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       ch;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_term_out;

    logic [7:0]         line_buf [LINE_DEPTH];
    int unsigned        fill;
    logic [LIMIT_W-1:0] limit_reg;
    t_term_out          terminal_output_q [$];
    int                 fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    task automatic report_mismatch(input string msg);
        if (fail_cnt < 100) $display("%0t ns: MISMATCH %s", $time, msg);
        fail_cnt++;
    endtask

    function automatic t_term_out out_item(input t_kind k, input logic [7:0] c,
                                           input logic [LEN_W-1:0] n);
        t_term_out r;
        r.kind = k;
        r.ch   = c;
        r.len  = n;
        r.last = 1'b0;
        return r;
    endfunction

    // Works out every result one received byte causes and updates the line state.
    function automatic void apply_keystroke(input logic [7:0] c);
        int unsigned lim;
        bit          done;
        int          i;
        t_term_out   burst [$];
        t_term_out   r;
        lim = limit_reg;
        if (lim < 2) lim = 2;
        if (lim > LINE_DEPTH) lim = LINE_DEPTH;
        done = 1'b0;
        if (c == CH_BS || c == CH_DEL) begin
            if (fill > 0) begin
                fill--;
                burst.push_back(out_item(KIND_ECHO, CH_BS, '0));
                burst.push_back(out_item(KIND_ECHO, CH_SPACE, '0));
                burst.push_back(out_item(KIND_ECHO, CH_BS, '0));
            end
        end else if (c == CH_CR || c == CH_LF) begin
            burst.push_back(out_item(KIND_ECHO, CH_LF, '0));
            done = 1'b1;
        end else if (c >= CH_SPACE && c < CH_DEL) begin
            burst.push_back(out_item(KIND_ECHO, c, '0));
            if (fill < LINE_DEPTH) begin
                line_buf[fill] = c;
                fill++;
            end
        end
        // A lowered limit can complete a line even on a byte that is otherwise ignored.
        if (fill >= lim - 1) done = 1'b1;
        if (done) begin
            for (i = 0; i < fill; i++) burst.push_back(out_item(KIND_CHAR, line_buf[i], '0));
            burst.push_back(out_item(KIND_END, 8'd0, LEN_W'(fill)));
            fill = 0;
        end
        for (i = 0; i < burst.size(); i++) begin
            r = burst[i];
            r.last = (i == burst.size() - 1);
            terminal_output_q.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_term_out want;
        if (!i_rst_n) begin
            terminal_output_q.delete();
            fill      = 0;
            limit_reg = LIMIT_RESET;
        end else begin
            if (i_cfg_we) limit_reg = i_cfg_data;
            if (i_in_valid && i_in_ready) apply_keystroke(i_rx_char);
            if (i_out_valid && i_out_ready) begin
                if (terminal_output_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind=%0d char=%0d len=%0d",
                                              i_out_kind, i_out_char, i_line_length));
                end else begin
                    want = terminal_output_q.pop_front();
                    if (i_out_kind !== want.kind)
                        report_mismatch($sformatf("out_kind %0d, expected %0d",
                                                  i_out_kind, want.kind));
                    if (i_out_char !== want.ch)
                        report_mismatch($sformatf("out_char %0d, expected %0d",
                                                  i_out_char, want.ch));
                    if (i_line_length !== want.len)
                        report_mismatch($sformatf("line_length %0d, expected %0d",
                                                  i_line_length, want.len));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last %0d, expected %0d",
                                                  i_last, want.last));
                end
            end
        end
        o_pending <= terminal_output_q.size();
    end

endmodule

@@ tb/terminal_line_editor_tb.sv @@
// Testbench top for the terminal line editor: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module terminal_line_editor_tb import tle_pkg::*;;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_rx_char;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_out_kind;
    logic [7:0]         o_out_char;
    logic [LEN_W-1:0]   o_line_length;
    logic               o_last;

    int pending;
    int fail_count;

    // Pacing state of the sender: requests go out in bursts, with gaps only when bursty is set.
    int unsigned burst_left = 1;
    bit          bursty     = 1'b1;
    // Raised once the random part starts; the receiver then does its long hold-off.
    bit          random_started = 1'b0;

    // Cycles to let pass after the last expected result, so that a byte that caused no
    // result has surely left the pipeline before the line limit changes.
    localparam int DRAIN_CYCLES = 16;

    terminal_line_editor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_char     (i_rx_char),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_kind    (o_out_kind),
        .o_out_char    (o_out_char),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

    terminal_line_editor_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_rx_char     (i_rx_char),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_kind    (o_out_kind),
        .i_out_char    (o_out_char),
        .i_line_length (o_line_length),
        .i_last        (o_last),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest correct run, long hold-off and drains included.
    initial begin
        #(10_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Offers one received byte and holds it until the block takes it. Valid stays high
    // into the next request of the same burst; a gap lowers it for a random stretch.
    task automatic offer(input logic [7:0] b);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_rx_char  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = bursty ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stops offering and waits until every expected result has been taken, then lets the
    // pipeline run empty so that the block is idle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_limit(input logic [LIMIT_W-1:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly typing: printable bytes, with some backspaces, line ends at the given rate,
    // and a share of arbitrary bytes, most of which the block ignores.
    function automatic logic [7:0] pick_keystroke(input int unsigned enter_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < enter_pct) return $urandom_range(0, 1) ? CH_CR : CH_LF;
        if (roll < enter_pct + 6) return $urandom_range(0, 1) ? CH_BS : CH_DEL;
        if (roll < enter_pct + 16) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    // The receiver stalls on its own pattern: fully open stretches, light and heavy
    // stalling, and once, early in the random part, a long hold-off so that the block
    // backs up and drops its input ready while the sender keeps offering.
    initial begin : out_ready_gen
        int unsigned mode;
        int unsigned span;
        bit          held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && random_started) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 60);
                repeat (span) begin
                    case (mode)
                        0: begin
                            i_out_ready <= 1'b1;
                        end
                        1, 2: begin
                            i_out_ready <= ($urandom_range(0, 3) != 0);
                        end
                        default: begin
                            i_out_ready <= ($urandom_range(0, 1) != 0);
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus_gen
        logic [7:0]         opening [0:17];
        logic [LIMIT_W-1:0] phase_limit [0:9];
        int unsigned        enter_pct;
        int unsigned        n_items;
        int                 p;
        int                 k;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_rx_char  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset limit of 32. Backspace and delete on an empty line,
        // ignored bytes at both ends of the byte range, CR and LF on empty lines, the edges
        // of the printable range, erasing with both backspace codes, and a short line.
        opening = '{CH_BS, CH_DEL, 8'd0, 8'd255, 8'd128, 8'd9, CH_CR, CH_LF,
                    CH_SPACE, 8'd126, 8'd65, CH_DEL, CH_BS, 8'd90, 8'd31, CH_CR,
                    8'd97, 8'd98};
        for (k = 0; k < 18; k++) offer(opening[k]);

        // Two characters are waiting; lowering the limit to its minimum makes the next
        // byte, although ignored, complete the line silently. After that every printable
        // byte is a line of its own.
        write_line_limit(LIMIT_MIN);
        offer(8'd200);
        offer(8'd120);

        // Random part: one phase per limit setting, out-of-range values included. Phases
        // near the full buffer send no line ends so that lines complete on the limit.
        // A partial line carried into a lower limit completes on its first byte if it reaches limit - 1.
        phase_limit = '{6'd63, 6'd0, 6'd1, 6'd3, 6'd5, 6'd32, 6'd33, 6'd31, 6'd0, 6'd0};
        phase_limit[8] = LIMIT_W'($urandom_range(0, 63));
        phase_limit[9] = LIMIT_W'($urandom_range(0, 63));
        for (p = 0; p < 10; p++) begin
            write_line_limit(phase_limit[p]);
            random_started = 1'b1;
            bursty    = (p % 3 != 0);
            enter_pct = (phase_limit[p] >= 6'd31) ? 0 : 10;
            n_items   = (enter_pct == 0) ? 35 : 15;
            for (k = 0; k < n_items; k++) offer(pick_keystroke(enter_pct));
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
